@@ sv/sstd_pkg.sv @@
// shared types and constants for the skid-steer throttle mixer
`default_nettype none

package sstd_pkg;

  // vector and speed limits
  localparam int VecMax = 255;
  localparam int VecMin = -255;

  // item kind
  typedef enum logic [0:0] {
    ACT_UPDATE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  // input item
  typedef struct packed {
    action_e            action;
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
    logic               tick_x;
    logic               tick_y;
    logic        [7:0]  step_x;
    logic        [7:0]  step_y;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [8:0]  speed;
    logic        [7:0]  duty;
    logic               bridge_a;
    logic               bridge_b;
  } out_t;

endpackage

`default_nettype wire

@@ sv/sstd_core.sv @@
// vector update, decay and mixing logic with the held state
`default_nettype none

module sstd_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire sstd_pkg::in_t item_i,
  input  wire logic          left_side_i,
  output sstd_pkg::out_t     result_o
);

  logic signed [8:0] turn_q, turn_d;
  logic signed [8:0] fwd_q, fwd_d;
  logic signed [8:0] speed_q, speed_d;
  logic              br_a_q, br_a_d;
  logic              br_b_q, br_b_d;
  logic              mix_en;
  logic signed [9:0] mix_sum;
  logic        [8:0] speed_neg;

  // clamp a 10-bit value to the vector range
  function automatic logic signed [8:0] sat10(input logic signed [9:0] v);
    logic signed [8:0] r;
    if (v > 10'(sstd_pkg::VecMax)) begin
      r = 9'(sstd_pkg::VecMax);
    end else if (v < 10'(sstd_pkg::VecMin)) begin
      r = 9'(sstd_pkg::VecMin);
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // move toward zero by step, snap to zero inside the step
  function automatic logic signed [8:0] decay(input logic signed [8:0] v,
                                              input logic        [7:0] step);
    logic signed [9:0] vv;
    logic signed [9:0] s;
    logic signed [9:0] t;
    logic signed [8:0] r;
    vv = 10'(v);
    s  = $signed({2'b00, step});
    if (vv > s) begin
      t = vv - s;
      r = t[8:0];
    end else if (vv < -s) begin
      t = vv + s;
      r = t[8:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // next vectors
  always_comb begin
    turn_d = turn_q;
    fwd_d  = fwd_q;
    mix_en = 1'b0;
    if (accept_i) begin
      if (item_i.action == sstd_pkg::ACT_UPDATE) begin
        turn_d = sat10(10'(turn_q) + 10'(item_i.delta_x));
        fwd_d  = sat10(10'(fwd_q) + 10'(item_i.delta_y));
        mix_en = 1'b1;
      end else if (item_i.tick_x || item_i.tick_y) begin
        if (item_i.tick_x) begin
          turn_d = decay(turn_q, item_i.step_x);
        end
        if (item_i.tick_y) begin
          fwd_d = decay(fwd_q, item_i.step_y);
        end
        mix_en = 1'b1;
      end
    end
  end

  // mix, clamp and pick bridge pins
  always_comb begin
    mix_sum = left_side_i ? (10'(fwd_d) + 10'(turn_d)) : (10'(fwd_d) - 10'(turn_d));
    speed_d = speed_q;
    br_a_d  = br_a_q;
    br_b_d  = br_b_q;
    if (mix_en) begin
      speed_d = sat10(mix_sum);
      br_a_d  = (speed_d <= 9'sd0);
      br_b_d  = (speed_d >= 9'sd0);
    end
  end

  // result from the new state
  always_comb begin
    speed_neg         = 9'(-speed_d);
    result_o.speed    = speed_d;
    result_o.duty     = speed_d[8] ? speed_neg[7:0] : speed_d[7:0];
    result_o.bridge_a = br_a_d;
    result_o.bridge_b = br_b_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q  <= '0;
      fwd_q   <= '0;
      speed_q <= '0;
      br_a_q  <= 1'b0;
      br_b_q  <= 1'b0;
    end else begin
      turn_q  <= turn_d;
      fwd_q   <= fwd_d;
      speed_q <= speed_d;
      br_a_q  <= br_a_d;
      br_b_q  <= br_b_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/sstd_out_buf.sv @@
// result register with a skid stage behind it
`default_nettype none

module sstd_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sstd_pkg::out_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output sstd_pkg::out_t      data_o
);

  logic           main_vld_q, main_vld_d;
  logic           skid_vld_q, skid_vld_d;
  sstd_pkg::out_t main_q, main_d;
  sstd_pkg::out_t skid_q, skid_d;
  logic           pop;

  // fill and drain of the two stages
  always_comb begin
    pop        = main_vld_q && !stall_i;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = push_i;
        main_d     = data_i;
      end
    end else if (push_i) begin
      if (main_vld_q) begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end else begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

endmodule

`default_nettype wire

@@ sv/skid_steer_throttle_decay.sv @@
// top level of the skid-steer throttle mixer with decay
//
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_stall_o in_data_i  (sstd_pkg::in_t)
//   out       output     out_valid_o/out_stall_i out_data_o (sstd_pkg::out_t)
//   cfg       input      cfg_we_i              cfg_wdata_i (left_side)
//
// one item per cycle unless stalled; its result is registered at the transfer
// state update, mix and clamp are done in the cycle of the input transfer
// a two-entry output stage lets input continue while one result waits
// input stalls only when both output entries are full
// reset clears the vectors, the last speed, the bridge pins and left_side
`default_nettype none

module skid_steer_throttle_decay (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sstd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sstd_pkg::out_t      out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i
);

  logic           left_side_q;
  logic           in_accept;
  logic           buf_full;
  sstd_pkg::out_t result;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_side_q <= 1'b0;
    end else if (cfg_we_i) begin
      left_side_q <= cfg_wdata_i;
    end
  end

  // input transfer
  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  sstd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .left_side_i (left_side_q),
    .result_o    (result)
  );

  sstd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/sstd_checker.sv @@
// port-level checks for the throttle mixer and their bind
`default_nettype none

module sstd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire sstd_pkg::out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // duty is the speed magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.speed[8] && out_data_o.duty == 8'(-out_data_o.speed))
                 || (!out_data_o.speed[8] && out_data_o.duty == out_data_o.speed[7:0]))
    else $error("duty does not match speed");

  // nonzero speed drives exactly one bridge pin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.speed != 9'sd0 |->
      out_data_o.bridge_a == out_data_o.speed[8] && out_data_o.bridge_b == !out_data_o.speed[8])
    else $error("bridge pins disagree with speed sign");

  // speed does not fall below the clamp range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.speed >= 9'(sstd_pkg::VecMin))
    else $error("speed below clamp range");

endmodule

bind skid_steer_throttle_decay sstd_checker u_sstd_checker (.*);

`default_nettype wire

@@ tb/skid_steer_throttle_decay_tb.sv @@
// self-checking testbench for the skid-steer throttle mixer with decay
module skid_steer_throttle_decay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sstd_pkg::*;

  // expected drive outputs, predicted from each accepted command
  class throttle_scoreboard;
    int   turn_vec;
    int   fwd_vec;
    bit   left_side;
    out_t last_drive;
    out_t expected_drive[$];
    int   errors;

    function new();
      turn_vec   = 0;
      fwd_vec    = 0;
      left_side  = 1'b0;
      last_drive = '0;
      errors     = 0;
    endfunction

    function int clamp_throttle(int v);
      if (v > VecMax) return VecMax;
      if (v < VecMin) return VecMin;
      return v;
    endfunction

    function int decay_toward_zero(int v, int step);
      if (v > step) return v - step;
      if (v < -step) return v + step;
      return 0;
    endfunction

    // mix the two vectors into speed, duty and bridge pins
    function void mix_drive();
      int s;
      int mag;
      s = clamp_throttle(left_side ? fwd_vec + turn_vec : fwd_vec - turn_vec);
      mag = (s < 0) ? -s : s;
      last_drive.speed    = s[8:0];
      last_drive.duty     = mag[7:0];
      last_drive.bridge_a = (s <= 0);
      last_drive.bridge_b = (s >= 0);
    endfunction

    // accepted command transfer: update state, queue the drive it yields
    function void add_command(in_t cmd);
      int dx;
      int dy;
      dx = $signed(cmd.delta_x);
      dy = $signed(cmd.delta_y);
      if (cmd.action == ACT_UPDATE) begin
        turn_vec = clamp_throttle(turn_vec + dx);
        fwd_vec  = clamp_throttle(fwd_vec + dy);
        mix_drive();
      end else if (cmd.tick_x || cmd.tick_y) begin
        if (cmd.tick_x) turn_vec = decay_toward_zero(turn_vec, int'(cmd.step_x));
        if (cmd.tick_y) fwd_vec = decay_toward_zero(fwd_vec, int'(cmd.step_y));
        mix_drive();
      end
      expected_drive.push_back(last_drive);
    endfunction

    // accepted drive transfer: compare with the oldest prediction
    function void check_drive(out_t got);
      out_t exp_d;
      if (expected_drive.size() == 0) begin
        $error("drive transfer with no command pending: speed %0d", $signed(got.speed));
        errors++;
        return;
      end
      exp_d = expected_drive.pop_front();
      if (got.speed !== exp_d.speed) begin
        $error("speed: expected %0d, got %0d", $signed(exp_d.speed), $signed(got.speed));
        errors++;
      end
      if (got.duty !== exp_d.duty) begin
        $error("duty: expected %0d, got %0d", exp_d.duty, got.duty);
        errors++;
      end
      if (got.bridge_a !== exp_d.bridge_a) begin
        $error("bridge_a: expected %0b, got %0b", exp_d.bridge_a, got.bridge_a);
        errors++;
      end
      if (got.bridge_b !== exp_d.bridge_b) begin
        $error("bridge_b: expected %0b, got %0b", exp_d.bridge_b, got.bridge_b);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  throttle_scoreboard sb = new();

  int stall_left = 0;
  int stretch_left = 0;
  bit quiet_stretch = 1'b0;
  bit steady_send = 1'b0;

  skid_steer_throttle_decay u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_drive(out_data);
      if (in_valid && !in_stall) sb.add_command(in_data);
    end
  end

  // receiver stalls: quiet stretches, short bursts, the odd long one
  always @(negedge clk_i) begin
    if (stretch_left == 0) begin
      quiet_stretch = ($urandom_range(0, 3) == 0);
      stretch_left = $urandom_range(50, 300);
    end else begin
      stretch_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (quiet_stretch || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) :
                   $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_send || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one command transfer; starts and ends just after a falling edge
  task automatic send_command(in_t cmd, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_update(logic signed [7:0] dx, logic signed [7:0] dy);
    in_t cmd;
    cmd = in_t'({$urandom, $urandom});
    cmd.action  = ACT_UPDATE;
    cmd.delta_x = dx;
    cmd.delta_y = dy;
    send_command(cmd, 0);
  endtask

  task automatic send_tick(logic tx, logic ty, logic [7:0] sx, logic [7:0] sy);
    in_t cmd;
    cmd = in_t'({$urandom, $urandom});
    cmd.action = ACT_TICK;
    cmd.tick_x = tx;
    cmd.tick_y = ty;
    cmd.step_x = sx;
    cmd.step_y = sy;
    send_command(cmd, 0);
  endtask

  // hold off the sender until every predicted drive has arrived
  task automatic drain_drives();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_drive.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_side(bit side);
    drain_drives();
    cfg_we    <= 1'b1;
    cfg_wdata <= side;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.left_side = side;
  endtask

  function automatic logic [7:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 50) return 8'($urandom_range(1, 15));
    if (r < 60) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'sd127;
    if (r < 24) return -8'sd128;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_t random_command();
    in_t cmd;
    cmd = in_t'({$urandom, $urandom});
    cmd.action  = $urandom_range(0, 1) ? ACT_TICK : ACT_UPDATE;
    cmd.delta_x = pick_delta();
    cmd.delta_y = pick_delta();
    cmd.step_x  = pick_step();
    cmd.step_y  = pick_step();
    return cmd;
  endfunction

  initial begin
    static bit phase_side[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle tick after reset, saturation, clamping, snap and zero step
    send_tick(1'b0, 1'b0, 8'd255, 8'd255);
    send_update(8'sd0, 8'sd0);
    send_update(8'sd127, 8'sd127);
    send_update(8'sd127, -8'sd128);
    send_update(8'sd127, -8'sd128);
    send_update(-8'sd128, -8'sd128);
    send_tick(1'b1, 1'b1, 8'd0, 8'd0);
    send_tick(1'b1, 1'b0, 8'd255, 8'd0);
    send_tick(1'b0, 1'b0, 8'd3, 8'd3);
    send_tick(1'b0, 1'b1, 8'd0, 8'd10);
    send_update(-8'sd128, 8'sd0);
    send_update(-8'sd128, 8'sd0);
    send_tick(1'b1, 1'b1, 8'd200, 8'd255);
    send_update(8'sd0, 8'sd127);
    send_update(8'sd0, 8'sd127);
    send_update(8'sd0, 8'sd127);
    write_side(1'b1);
    send_update(8'sd127, 8'sd0);
    send_update(8'sd127, 8'sd0);
    send_update(8'sd127, 8'sd127);
    send_tick(1'b1, 1'b1, 8'd1, 8'd1);
    send_tick(1'b1, 1'b1, 8'd254, 8'd254);
    send_update(-8'sd128, 8'sd5);
    send_tick(1'b0, 1'b1, 8'd0, 8'd5);

    // random phases, one side setting each
    foreach (phase_side[p]) begin
      write_side(phase_side[p]);
      for (int i = 0; i < 150; i++) begin
        if (i % 50 == 0) steady_send = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 99) < 2) drain_drives();
        send_command(random_command(), pick_gap());
      end
    end

    // wind down and give the last drive time to show
    drain_drives();
    repeat (10) @(negedge clk_i);
    if (sb.expected_drive.size() != 0) begin
      $error("%0d predicted drives never arrived", sb.expected_drive.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sstd_pkg.sv
sv/sstd_core.sv
sv/sstd_out_buf.sv
sv/skid_steer_throttle_decay.sv
sv/sstd_checker.sv
tb/skid_steer_throttle_decay_tb.sv
